>>> rtl/amg_pkg.sv
// Package for the adjacency matrix graph table.
// Holds opcodes, status codes, the slot count default and the item types.
// No dependencies.
`timescale 1ns / 1ps

package amg_pkg;

	localparam int AMG_SLOTS = 16;
	localparam int NAME_W    = 8;
	localparam int NAME_CNT  = 256;

	localparam logic [2:0] OP_ADD_VERTEX  = 3'd0;
	localparam logic [2:0] OP_DEL_VERTEX  = 3'd1;
	localparam logic [2:0] OP_ADD_EDGE    = 3'd2;
	localparam logic [2:0] OP_DEL_EDGE    = 3'd3;
	localparam logic [2:0] OP_SEARCH_EDGE = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXISTS    = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NO_VERTEX = 2'd3;

	typedef struct packed {
		logic [2:0]        op;
		logic [NAME_W-1:0] first_name;
		logic [NAME_W-1:0] second_name;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       edge_present;
		logic [3:0] slot_used;
		logic       graph_empty;
	} rsp_item_t;

endpackage

>>> rtl/amg_adj_mem.sv
// Adjacency row memory: SLOTS rows of SLOTS bits, one read and one write port.
// Per-row valid bits make unwritten rows read as zero after reset.
// Depends on amg_pkg.
`timescale 1ns / 1ps

module amg_adj_mem import amg_pkg::*; #(
	parameter int SLOTS = AMG_SLOTS,
	parameter int SW    = $clog2(SLOTS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SW-1:0]    rd_addr,
	output logic [SLOTS-1:0] rd_data,
	input  logic             wr_en,
	input  logic [SW-1:0]    wr_addr,
	input  logic [SLOTS-1:0] wr_data
);

	logic [SLOTS-1:0] mem [SLOTS];
	logic [SLOTS-1:0] row_vld_q;
	logic [SLOTS-1:0] rd_q;
	logic             rdv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			rdv_q <= row_vld_q[rd_addr];
		end
	end

	assign rd_data = rdv_q ? rd_q : '0;

endmodule

>>> rtl/adjacency_matrix_graph_table.sv
// Top level of the adjacency matrix graph table.
// Depends on amg_pkg and amg_adj_mem.
//
// Usage:
//   req carries one operation (add/delete vertex, add/delete/search edge by
//   name); rsp returns exactly one result item per request, in order.
//   Both channels use valid/stall; an item moves when valid is high and
//   stall is low.
//   One operation is in flight at a time. The accepted item's name lookups
//   are registered; add vertex, failed lookups and unused opcodes finish
//   in the lookup state; search edge or a self-loop edge finishes after
//   reading the first row; add/delete edge also updates the second row;
//   delete vertex sweeps every adjacency row to clear the column. The next
//   item is taken once the block is back in idle. Each step is bound by
//   the registered read of the name map and the adjacency row memory.
//   A result waits in the output register while rsp_stall is high; one more
//   item may be accepted and finished into a holding register, after which
//   req_stall stays high until the output drains.
//   Reset empties the graph at once: name valid bits and row valid bits are
//   cleared, no clearing pass is needed.
`timescale 1ns / 1ps

module adjacency_matrix_graph_table import amg_pkg::*; #(
	parameter int SLOTS = AMG_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [SLOTS-1:0] ROW_ONE = SLOTS'(1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_EDGE1 = 3'd2;
	localparam logic [2:0] S_EDGE2 = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;

	logic [2:0]        state_q, state_nxt;
	logic [2:0]        op_q;
	logic [NAME_W-1:0] n1_q;
	logic              v1_q, v2_q;
	logic [SW-1:0]     s1_q, s2_q, stk_q;
	logic [CW-1:0]     fcnt_q, fcnt_nxt, fcnt_plus;
	logic [CW-1:0]     hw_q, hw_nxt;
	logic [CW-1:0]     wcnt_q;
	logic              wpend_s1;
	logic [SW-1:0]     waddr_s1;

	logic [NAME_CNT-1:0] name_vld_q;
	logic [SW-1:0]       map_mem [NAME_CNT];
	logic [SW-1:0]       stk_mem [SLOTS];

	logic          acc, fin, map_we, vld_clr, stk_we;
	logic [SW-1:0] new_slot, slot_sel;
	rsp_item_t     res;

	logic             adj_rd_en, adj_wr_en;
	logic [SW-1:0]    adj_rd_addr, adj_wr_addr;
	logic [SLOTS-1:0] adj_rd_data, adj_wr_data;

	logic      out_vld_q, pend_vld_q;
	rsp_item_t out_q, pend_q;

	assign req_stall = (state_q != S_IDLE) || pend_vld_q;
	assign acc       = req_valid && !req_stall;

	amg_adj_mem #(.SLOTS(SLOTS), .SW(SW)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adj_rd_en),
		.rd_addr (adj_rd_addr),
		.rd_data (adj_rd_data),
		.wr_en   (adj_wr_en),
		.wr_addr (adj_wr_addr),
		.wr_data (adj_wr_data)
	);

	always_comb begin
		fin         = 1'b0;
		res         = '0;
		slot_sel    = '0;
		state_nxt   = state_q;
		map_we      = 1'b0;
		vld_clr     = 1'b0;
		stk_we      = 1'b0;
		new_slot    = stk_q;
		fcnt_nxt    = fcnt_q;
		hw_nxt      = hw_q;
		fcnt_plus   = fcnt_q;
		adj_rd_en   = 1'b0;
		adj_rd_addr = s1_q;
		adj_wr_en   = 1'b0;
		adj_wr_addr = s1_q;
		adj_wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				unique case (op_q)
					OP_ADD_VERTEX: begin
						fin = 1'b1;
						if (v1_q) begin
							res.status = ST_EXISTS;
							slot_sel   = s1_q;
						end else if (fcnt_q != '0) begin
							new_slot = stk_q;
							fcnt_nxt = fcnt_q - CW'(1);
							map_we   = 1'b1;
							slot_sel = stk_q;
						end else if (hw_q == CW'(SLOTS)) begin
							res.status = ST_FULL;
						end else begin
							new_slot = hw_q[SW-1:0];
							hw_nxt   = hw_q + CW'(1);
							map_we   = 1'b1;
							slot_sel = hw_q[SW-1:0];
						end
					end
					OP_DEL_VERTEX: begin
						if (!v1_q) begin
							fin        = 1'b1;
							res.status = ST_NO_VERTEX;
						end else begin
							state_nxt = S_WALK;
						end
					end
					OP_ADD_EDGE, OP_DEL_EDGE, OP_SEARCH_EDGE: begin
						if (!v1_q || !v2_q) begin
							fin        = 1'b1;
							res.status = ST_NO_VERTEX;
							slot_sel   = v1_q ? s1_q : '0;
						end else begin
							adj_rd_en = 1'b1;
							state_nxt = S_EDGE1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_EDGE1: begin
				slot_sel = s1_q;
				if (op_q == OP_SEARCH_EDGE) begin
					fin              = 1'b1;
					res.edge_present = adj_rd_data[s2_q];
				end else begin
					adj_wr_en   = 1'b1;
					adj_wr_data = (op_q == OP_ADD_EDGE) ? (adj_rd_data | (ROW_ONE << s2_q))
						: (adj_rd_data & ~(ROW_ONE << s2_q));
					if (s1_q == s2_q) begin
						fin = 1'b1;
					end else begin
						adj_rd_en   = 1'b1;
						adj_rd_addr = s2_q;
						state_nxt   = S_EDGE2;
					end
				end
			end
			S_EDGE2: begin
				fin         = 1'b1;
				slot_sel    = s1_q;
				adj_wr_en   = 1'b1;
				adj_wr_addr = s2_q;
				adj_wr_data = (op_q == OP_ADD_EDGE) ? (adj_rd_data | (ROW_ONE << s1_q))
					: (adj_rd_data & ~(ROW_ONE << s1_q));
			end
			S_WALK: begin
				adj_rd_en   = (wcnt_q != CW'(SLOTS));
				adj_rd_addr = wcnt_q[SW-1:0];
				if (wpend_s1) begin
					adj_wr_en   = 1'b1;
					adj_wr_addr = waddr_s1;
					adj_wr_data = (waddr_s1 == s1_q) ? '0 : (adj_rd_data & ~(ROW_ONE << s1_q));
				end
				if (wpend_s1 && (wcnt_q == CW'(SLOTS))) begin
					fin      = 1'b1;
					slot_sel = s1_q;
					vld_clr  = 1'b1;
					if (fcnt_q < CW'(SLOTS)) begin
						stk_we    = 1'b1;
						fcnt_plus = fcnt_q + CW'(1);
					end
					if ((hw_q != '0) && (fcnt_plus == hw_q)) begin
						fcnt_nxt = '0;
						hw_nxt   = '0;
					end else begin
						fcnt_nxt = fcnt_plus;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
		if (fin) begin
			state_nxt = S_IDLE;
		end
		res.slot_used   = 4'(slot_sel);
		res.graph_empty = (hw_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fcnt_q     <= '0;
			hw_q       <= '0;
			wcnt_q     <= '0;
			wpend_s1   <= 1'b0;
			name_vld_q <= '0;
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			fcnt_q  <= fcnt_nxt;
			hw_q    <= hw_nxt;
			if (state_q == S_LOOK) begin
				wcnt_q   <= '0;
				wpend_s1 <= 1'b0;
			end else if (state_q == S_WALK) begin
				if (adj_rd_en) begin
					wcnt_q <= wcnt_q + CW'(1);
				end
				wpend_s1 <= adj_rd_en;
			end
			if (map_we) begin
				name_vld_q[n1_q] <= 1'b1;
			end else if (vld_clr) begin
				name_vld_q[n1_q] <= 1'b0;
			end
			if (!out_vld_q || !rsp_stall) begin
				if (pend_vld_q) begin
					out_vld_q  <= 1'b1;
					pend_vld_q <= 1'b0;
				end else begin
					out_vld_q <= fin;
				end
			end else if (fin) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= req.op;
			n1_q  <= req.first_name;
			v1_q  <= name_vld_q[req.first_name];
			v2_q  <= name_vld_q[req.second_name];
			s1_q  <= map_mem[req.first_name];
			s2_q  <= map_mem[req.second_name];
			stk_q <= stk_mem[SW'(fcnt_q - CW'(1))];
		end
		if (map_we) begin
			map_mem[n1_q] <= new_slot;
		end
		if (stk_we) begin
			stk_mem[fcnt_q[SW-1:0]] <= s1_q;
		end
		if (state_q == S_WALK) begin
			waddr_s1 <= wcnt_q[SW-1:0];
		end
		if (!out_vld_q || !rsp_stall) begin
			if (pend_vld_q) begin
				out_q <= pend_q;
			end else if (fin) begin
				out_q <= res;
			end
		end else if (fin) begin
			pend_q <= res;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

>>> rtl/amg_checker.sv
// Port-level checks for the adjacency matrix graph table, with its bind.
// Depends on amg_pkg and adjacency_matrix_graph_table.
`timescale 1ns / 1ps

module amg_checker import amg_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_item_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item accepted while one is in flight");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |->
		(rsp.slot_used == 4'd0) && !rsp.edge_present && !rsp.graph_empty)
		else $error("full status with bad result fields");

	a_edge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.edge_present |-> (rsp.status == ST_OK) && !rsp.graph_empty)
		else $error("edge reported without a good lookup");

	a_exists_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EXISTS) |-> !rsp.graph_empty && !rsp.edge_present)
		else $error("existing vertex reported in an empty graph");

endmodule

bind adjacency_matrix_graph_table amg_checker u_amg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
